>>> rtl/core/h264_sps_field_parser_top_assert.svh
// ----------------------------------------------------------------------------
// SPS field parser assertion macros
// Concurrent assertion wrappers for the SPS field parser; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef H264_SPS_FIELD_PARSER_TOP_ASSERT_SVH
`define H264_SPS_FIELD_PARSER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SFP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("SPS parser assertion failed");
// Next-cycle implication.
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("SPS parser assertion failed");
`else
`define SFP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/sfp_pkg.sv
// ----------------------------------------------------------------------------
// SPS field parser package
// Parse phase codes, field widths, status codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sfp_pkg;

   // Result status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NOT_SPS   = 3'd1;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd2;
   localparam logic [2:0] STATUS_SCALING   = 3'd3;
   localparam logic [2:0] STATUS_RANGE     = 3'd4;

   // Parse phases, one per syntax element.
   localparam logic [5:0] PH_HDR    = 6'd0;
   localparam logic [5:0] PH_PROF   = 6'd1;
   localparam logic [5:0] PH_CONS   = 6'd2;
   localparam logic [5:0] PH_LEVEL  = 6'd3;
   localparam logic [5:0] PH_ID     = 6'd4;
   localparam logic [5:0] PH_CHROMA = 6'd5;
   localparam logic [5:0] PH_SEP    = 6'd6;
   localparam logic [5:0] PH_LUMA   = 6'd7;
   localparam logic [5:0] PH_CDEPTH = 6'd8;
   localparam logic [5:0] PH_BYPASS = 6'd9;
   localparam logic [5:0] PH_SMF    = 6'd10;
   localparam logic [5:0] PH_SLIST  = 6'd11;
   localparam logic [5:0] PH_FRNUM  = 6'd12;
   localparam logic [5:0] PH_POCT   = 6'd13;
   localparam logic [5:0] PH_POCLSB = 6'd14;
   localparam logic [5:0] PH_DZERO  = 6'd15;
   localparam logic [5:0] PH_OFFNR  = 6'd16;
   localparam logic [5:0] PH_OFFTB  = 6'd17;
   localparam logic [5:0] PH_NCYC   = 6'd18;
   localparam logic [5:0] PH_CYCOFF = 6'd19;
   localparam logic [5:0] PH_MAXREF = 6'd20;
   localparam logic [5:0] PH_GAPS   = 6'd21;
   localparam logic [5:0] PH_WMBS   = 6'd22;
   localparam logic [5:0] PH_HMAP   = 6'd23;
   localparam logic [5:0] PH_FMBS   = 6'd24;
   localparam logic [5:0] PH_MBAFF  = 6'd25;
   localparam logic [5:0] PH_D8     = 6'd26;
   localparam logic [5:0] PH_CROPF  = 6'd27;
   localparam logic [5:0] PH_CL     = 6'd28;
   localparam logic [5:0] PH_CR     = 6'd29;
   localparam logic [5:0] PH_CT     = 6'd30;
   localparam logic [5:0] PH_CB     = 6'd31;
   localparam logic [5:0] PH_VUI    = 6'd32;
   localparam logic [5:0] PH_ARF    = 6'd33;
   localparam logic [5:0] PH_ARIDC  = 6'd34;
   localparam logic [5:0] PH_SARW   = 6'd35;
   localparam logic [5:0] PH_SARH   = 6'd36;
   localparam logic [5:0] PH_OVF    = 6'd37;
   localparam logic [5:0] PH_OVA    = 6'd38;
   localparam logic [5:0] PH_VSF    = 6'd39;
   localparam logic [5:0] PH_VFMT   = 6'd40;
   localparam logic [5:0] PH_VFR    = 6'd41;
   localparam logic [5:0] PH_CDF    = 6'd42;
   localparam logic [5:0] PH_CP     = 6'd43;
   localparam logic [5:0] PH_TC     = 6'd44;
   localparam logic [5:0] PH_MC     = 6'd45;
   localparam logic [5:0] PH_CLF    = 6'd46;
   localparam logic [5:0] PH_CLT    = 6'd47;
   localparam logic [5:0] PH_CLB    = 6'd48;
   localparam logic [5:0] PH_TIF    = 6'd49;
   localparam logic [5:0] PH_NUT    = 6'd50;
   localparam logic [5:0] PH_TS     = 6'd51;
   localparam logic [5:0] PH_FFR    = 6'd52;
   localparam logic [5:0] PH_DONE   = 6'd53;
   localparam logic [5:0] PH_HALT   = 6'd54;

   // Parsed fields handed from the parser to the top level.
   typedef struct packed {
      logic [5:0]  phase;
      logic [2:0]  err;
      logic [7:0]  profile_idc;
      logic [7:0]  level_idc;
      logic [4:0]  sps_index;
      logic [7:0]  max_ref_frames;
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic [15:0] sar_width;
      logic [15:0] sar_height;
   } sfp_fields_type;

   // Fixed width of each phase; zero marks an Exp-Golomb code.
   function automatic logic [5:0] phase_width(input logic [5:0] ph);
      logic [5:0] w;
      unique case (ph) inside
         PH_HDR, PH_PROF, PH_CONS, PH_LEVEL, PH_ARIDC, PH_CP, PH_TC, PH_MC: w = 6'd8;
         PH_SEP, PH_BYPASS, PH_SMF, PH_SLIST, PH_DZERO, PH_GAPS, PH_FMBS, PH_MBAFF,
         PH_D8, PH_CROPF, PH_VUI, PH_ARF, PH_OVF, PH_OVA, PH_VSF, PH_VFR, PH_CDF,
         PH_CLF, PH_TIF, PH_FFR: w = 6'd1;
         PH_SARW, PH_SARH: w = 6'd16;
         PH_VFMT: w = 6'd3;
         PH_NUT, PH_TS: w = 6'd32;
         default: w = 6'd0;
      endcase
      return w;
   endfunction

   // Profiles that carry the chroma and bit-depth branch.
   function automatic logic high_profile(input logic [7:0] p);
      return (p == 8'd44) || (p == 8'd83) || (p == 8'd86) || (p == 8'd100) ||
             (p == 8'd110) || (p == 8'd118) || (p == 8'd122) || (p == 8'd244);
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/sfp_divider.sv
// ----------------------------------------------------------------------------
// SPS parser divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sfp_divider (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [31:0] dividend,
   input  wire  [32:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [33:0] trial;
   logic        fits;

   // One restoring step per cycle; dividend bits shift out of the quotient register.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[31]};
      fits    = trial >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 33'(trial - {1'b0, dvs_ff}) : trial[32:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/core/sfp_field_parser.sv
// ----------------------------------------------------------------------------
// SPS bit parser
// Consumes one payload bit per cycle while bit_valid is high and walks the SPS syntax elements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sfp_field_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   clear,
   input  wire                   bit_valid,
   input  wire                   bit_value,
   output sfp_pkg::sfp_fields_type fields,
   output logic                  div_start,
   output logic [31:0]           div_dividend,
   output logic [32:0]           div_divisor
);
   import sfp_pkg::*;

   logic [5:0]  phase_ff, phase_in;
   logic        ue_ff, ue_in;
   logic [5:0]  gz_ff, gz_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  left_ff, left_in;
   logic [7:0]  loop_ff, loop_in;
   logic        c444_ff, c444_in;
   logic        fo_ff, fo_in;
   logic [31:0] wmbs_ff, wmbs_in;
   logic [31:0] hu_ff, hu_in;
   logic [32:0] ch_ff, ch_in;
   logic [32:0] cv_ff, cv_in;
   logic [31:0] tick_ff, tick_in;
   logic [31:0] ts_ff, ts_in;
   logic [2:0]  err_ff, err_in;
   logic [7:0]  prof_ff, prof_in;
   logic [7:0]  lev_ff, lev_in;
   logic [4:0]  id_ff, id_in;
   logic [7:0]  mref_ff, mref_in;
   logic [15:0] fw_ff, fw_in;
   logic [15:0] fh_ff, fh_in;
   logic [15:0] sarw_ff, sarw_in;
   logic [15:0] sarh_ff, sarh_in;

   logic        fin, go;
   logic [5:0]  nxt;
   logic [31:0] fval;
   logic [31:0] acc_shift;
   logic [5:0]  left_dec;
   logic [31:0] gmask;
   logic [32:0] cv_use;
   logic [37:0] full_w, full_h, sub_w, sub_h, diff_w, diff_h;
   logic        w_bad, h_bad;

   always_comb begin
      phase_in = phase_ff;  ue_in   = ue_ff;    gz_in   = gz_ff;    acc_in  = acc_ff;
      left_in  = left_ff;   loop_in = loop_ff;  c444_in = c444_ff;  fo_in   = fo_ff;
      wmbs_in  = wmbs_ff;   hu_in   = hu_ff;    ch_in   = ch_ff;    cv_in   = cv_ff;
      tick_in  = tick_ff;   ts_in   = ts_ff;    err_in  = err_ff;   prof_in = prof_ff;
      lev_in   = lev_ff;    id_in   = id_ff;    mref_in = mref_ff;  fw_in   = fw_ff;
      fh_in    = fh_ff;     sarw_in = sarw_ff;  sarh_in = sarh_ff;
      fin       = 1'b0;
      go        = 1'b0;
      nxt       = phase_ff;
      fval      = '0;
      div_start = 1'b0;
      acc_shift = {acc_ff[30:0], bit_value};
      left_dec  = (left_ff != 6'd0) ? left_ff - 6'd1 : 6'd0;
      gmask     = ~(32'hFFFF_FFFF << gz_ff[4:0]);

      // Bit intake: Exp-Golomb prefix counting or shifting into the field.
      if (bit_valid && (phase_ff < PH_DONE)) begin
         if (ue_ff) begin
            if (!bit_value) begin
               gz_in = gz_ff + 6'd1;
               if (gz_ff == 6'd31) begin
                  phase_in = PH_HALT;
                  err_in   = STATUS_RANGE;
               end
            end else if (gz_ff == 6'd0) begin
               fin = 1'b1;
            end else begin
               ue_in   = 1'b0;
               left_in = gz_ff;
               acc_in  = '0;
            end
         end else begin
            acc_in  = acc_shift;
            left_in = left_dec;
            if (left_dec == 6'd0) begin
               fin  = 1'b1;
               fval = acc_shift + ((phase_width(phase_ff) == 6'd0) ? gmask : 32'd0);
            end
         end
      end

      // Cropped size arithmetic: full extent minus twice the crop sum.
      cv_use = (phase_ff == PH_CB) ? cv_ff + {1'b0, fval} : cv_ff;
      full_w = (38'(wmbs_ff) + 38'd1) << 4;
      full_h = ((38'(hu_ff) + 38'd1) << 4) << (fo_ff ? 1'b0 : 1'b1);
      sub_w  = 38'(ch_ff) << 1;
      sub_h  = 38'(cv_use) << 1;
      diff_w = full_w - sub_w;
      diff_h = full_h - sub_h;
      w_bad  = (sub_w > full_w) || (diff_w[37:16] != '0);
      h_bad  = (sub_h > full_h) || (diff_h[37:16] != '0);

      // Syntax element completion.
      if (fin) begin
         go = 1'b1;
         unique case (phase_ff)
            PH_HDR: begin
               if (fval[4:0] != 5'd7) begin
                  go = 1'b0;  phase_in = PH_HALT;  err_in = STATUS_NOT_SPS;
               end else begin
                  nxt = PH_PROF;
               end
            end
            PH_PROF:  begin prof_in = fval[7:0]; nxt = PH_CONS; end
            PH_CONS:  nxt = PH_LEVEL;
            PH_LEVEL: begin lev_in = fval[7:0]; nxt = PH_ID; end
            PH_ID: begin
               if (fval > 32'd31) begin
                  id_in = 5'd31;
                  if (err_ff == STATUS_OK) err_in = STATUS_RANGE;
               end else begin
                  id_in = fval[4:0];
               end
               nxt = high_profile(prof_ff) ? PH_CHROMA : PH_FRNUM;
            end
            PH_CHROMA: begin
               c444_in = (fval == 32'd3);
               nxt     = (fval == 32'd3) ? PH_SEP : PH_LUMA;
            end
            PH_SEP:    nxt = PH_LUMA;
            PH_LUMA:   nxt = PH_CDEPTH;
            PH_CDEPTH: nxt = PH_BYPASS;
            PH_BYPASS: nxt = PH_SMF;
            PH_SMF: begin
               loop_in = '0;
               nxt     = (fval != 32'd0) ? PH_SLIST : PH_FRNUM;
            end
            PH_SLIST: begin
               if (fval != 32'd0) begin
                  go = 1'b0;  phase_in = PH_HALT;  err_in = STATUS_SCALING;
               end else begin
                  loop_in = loop_ff + 8'd1;
                  nxt = ((loop_ff + 8'd1) >= (c444_ff ? 8'd12 : 8'd8)) ? PH_FRNUM : PH_SLIST;
               end
            end
            PH_FRNUM: nxt = PH_POCT;
            PH_POCT: begin
               if (fval == 32'd0)      nxt = PH_POCLSB;
               else if (fval == 32'd1) nxt = PH_DZERO;
               else                    nxt = PH_MAXREF;
            end
            PH_POCLSB: nxt = PH_MAXREF;
            PH_DZERO:  nxt = PH_OFFNR;
            PH_OFFNR:  nxt = PH_OFFTB;
            PH_OFFTB:  nxt = PH_NCYC;
            PH_NCYC: begin
               if (fval > 32'd255) begin
                  go = 1'b0;  phase_in = PH_HALT;  err_in = STATUS_RANGE;
               end else begin
                  loop_in = fval[7:0];
                  nxt     = (fval == 32'd0) ? PH_MAXREF : PH_CYCOFF;
               end
            end
            PH_CYCOFF: begin
               loop_in = loop_ff - 8'd1;
               nxt     = ((loop_ff - 8'd1) == 8'd0) ? PH_MAXREF : PH_CYCOFF;
            end
            PH_MAXREF: begin
               if (fval > 32'd255) begin
                  mref_in = 8'hFF;
                  if (err_ff == STATUS_OK) err_in = STATUS_RANGE;
               end else begin
                  mref_in = fval[7:0];
               end
               nxt = PH_GAPS;
            end
            PH_GAPS:  nxt = PH_WMBS;
            PH_WMBS:  begin wmbs_in = fval; nxt = PH_HMAP; end
            PH_HMAP:  begin hu_in = fval; nxt = PH_FMBS; end
            PH_FMBS: begin
               fo_in = fval[0];
               nxt   = (fval != 32'd0) ? PH_D8 : PH_MBAFF;
            end
            PH_MBAFF: nxt = PH_D8;
            PH_D8:    nxt = PH_CROPF;
            PH_CROPF, PH_CB: begin
               if ((phase_ff == PH_CROPF) && (fval != 32'd0)) begin
                  nxt = PH_CL;
               end else begin
                  cv_in = cv_use;
                  fw_in = w_bad ? 16'd0 : diff_w[15:0];
                  fh_in = h_bad ? 16'd0 : diff_h[15:0];
                  if ((w_bad || h_bad) && (err_ff == STATUS_OK)) err_in = STATUS_RANGE;
                  nxt = PH_VUI;
               end
            end
            PH_CL:    begin ch_in = {1'b0, fval}; nxt = PH_CR; end
            PH_CR:    begin ch_in = ch_ff + {1'b0, fval}; nxt = PH_CT; end
            PH_CT:    begin cv_in = {1'b0, fval}; nxt = PH_CB; end
            PH_VUI:   nxt = (fval != 32'd0) ? PH_ARF : PH_DONE;
            PH_ARF:   nxt = (fval != 32'd0) ? PH_ARIDC : PH_OVF;
            PH_ARIDC: nxt = (fval == 32'd255) ? PH_SARW : PH_OVF;
            PH_SARW:  begin sarw_in = fval[15:0]; nxt = PH_SARH; end
            PH_SARH:  begin sarh_in = fval[15:0]; nxt = PH_OVF; end
            PH_OVF:   nxt = (fval != 32'd0) ? PH_OVA : PH_VSF;
            PH_OVA:   nxt = PH_VSF;
            PH_VSF:   nxt = (fval != 32'd0) ? PH_VFMT : PH_CLF;
            PH_VFMT:  nxt = PH_VFR;
            PH_VFR:   nxt = PH_CDF;
            PH_CDF:   nxt = (fval != 32'd0) ? PH_CP : PH_CLF;
            PH_CP:    nxt = PH_TC;
            PH_TC:    nxt = PH_MC;
            PH_MC:    nxt = PH_CLF;
            PH_CLF:   nxt = (fval != 32'd0) ? PH_CLT : PH_TIF;
            PH_CLT:   nxt = PH_CLB;
            PH_CLB:   nxt = PH_TIF;
            PH_TIF:   nxt = (fval != 32'd0) ? PH_NUT : PH_DONE;
            PH_NUT:   begin tick_in = fval; nxt = PH_TS; end
            PH_TS:    begin ts_in = fval; nxt = PH_FFR; end
            PH_FFR: begin
               div_start = (fval != 32'd0) && (tick_ff != 32'd0);
               nxt       = PH_DONE;
            end
            default: begin
               go       = 1'b0;
               phase_in = PH_HALT;
            end
         endcase
      end

      // Start of the next syntax element.
      if (go) begin
         phase_in = nxt;
         acc_in   = '0;
         gz_in    = '0;
         ue_in    = (phase_width(nxt) == 6'd0);
         left_in  = phase_width(nxt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff <= PH_HDR;  ue_ff   <= 1'b0;  gz_ff   <= '0;  acc_ff  <= '0;
         left_ff  <= 6'd8;    loop_ff <= '0;    c444_ff <= 1'b0; fo_ff  <= 1'b1;
         wmbs_ff  <= '0;      hu_ff   <= '0;    ch_ff   <= '0;  cv_ff   <= '0;
         tick_ff  <= '0;      ts_ff   <= '0;    err_ff  <= STATUS_OK;
         prof_ff  <= '0;      lev_ff  <= '0;    id_ff   <= '0;  mref_ff <= '0;
         fw_ff    <= '0;      fh_ff   <= '0;    sarw_ff <= '0;  sarh_ff <= '0;
      end else begin
         phase_ff <= phase_in;  ue_ff   <= ue_in;    gz_ff   <= gz_in;    acc_ff  <= acc_in;
         left_ff  <= left_in;   loop_ff <= loop_in;  c444_ff <= c444_in;  fo_ff   <= fo_in;
         wmbs_ff  <= wmbs_in;   hu_ff   <= hu_in;    ch_ff   <= ch_in;    cv_ff   <= cv_in;
         tick_ff  <= tick_in;   ts_ff   <= ts_in;    err_ff  <= err_in;
         prof_ff  <= prof_in;   lev_ff  <= lev_in;   id_ff   <= id_in;    mref_ff <= mref_in;
         fw_ff    <= fw_in;     fh_ff   <= fh_in;    sarw_ff <= sarw_in;  sarh_ff <= sarh_in;
      end
   end

   assign fields.phase          = phase_ff;
   assign fields.err            = err_ff;
   assign fields.profile_idc    = prof_ff;
   assign fields.level_idc      = lev_ff;
   assign fields.sps_index      = id_ff;
   assign fields.max_ref_frames = mref_ff;
   assign fields.frame_width    = fw_ff;
   assign fields.frame_height   = fh_ff;
   assign fields.sar_width      = sarw_ff;
   assign fields.sar_height     = sarh_ff;
   assign div_dividend          = ts_ff;
   assign div_divisor           = {tick_ff, 1'b0};

endmodule
`default_nettype wire

>>> rtl/core/h264_sps_field_parser_top.sv
// A byte is accepted in ST_IDLE and shifted into the bit parser in ST_BITS, one bit at a time;
// ST_FINISH then registers the result transaction. A dropped last byte goes straight to ST_FINISH.
// ST_FINISH holds until the frame rate division has finished and its quotient is registered
// in fr_ff, and until the result register is free or being taken.
// Byte intake: a new byte is accepted only in ST_IDLE, after the previous byte's bits have shifted out.
// Synchronous active-high reset returns the parser to the NAL header phase.
// ----------------------------------------------------------------------------
// SPS field parser top level
// Strips emulation-prevention bytes and feeds the bit parser and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "h264_sps_field_parser_top_assert.svh"
module h264_sps_field_parser_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // data_byte
   input  wire          req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // status, profile_idc, level_idc, sps_index, max_ref_frames, frame_width,
   // frame_height, frame_rate, sar_width, sar_height
   output logic [111:0] rsp_tdata
);
   import sfp_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_BITS   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [1:0]     zr_ff, zr_in;
   logic [7:0]     sh_ff, sh_in;
   logic [2:0]     bit_cnt_ff, bit_cnt_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [111:0]   rsp_data_ff, rsp_data_in;
   logic [15:0]    fr_ff, fr_in;
   logic           accept, drop, emit;
   logic [2:0]     status;
   sfp_fields_type fields;
   logic           div_start, div_busy, div_done;
   logic [31:0]    div_dividend, div_quotient;
   logic [32:0]    div_divisor;

   sfp_field_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .clear        (emit),
      .bit_valid    (state_ff == ST_BITS),
      .bit_value    (sh_ff[7]),
      .fields       (fields),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor)
   );

   sfp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign accept = req_tvalid && req_tready;
   assign drop   = (zr_ff == 2'd2) && (req_tdata == 8'h03);
   // The quotient lands in fr_ff in the cycle after done, so the result waits for it.
   assign emit   = (state_ff == ST_FINISH) && !div_busy && !div_done &&
                   (!rsp_valid_ff || rsp_tready);

   // Final status from the parse phase.
   always_comb begin
      if (fields.phase == PH_HALT)      status = fields.err;
      else if (fields.phase != PH_DONE) status = STATUS_TRUNCATED;
      else                              status = fields.err;
   end

   // Byte intake, bit sequencing and result register.
   always_comb begin
      state_in     = state_ff;
      zr_in        = zr_ff;
      sh_in        = sh_ff;
      bit_cnt_in   = bit_cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      fr_in        = fr_ff;
      if (div_done) fr_in = (div_quotient[31:16] != '0) ? 16'hFFFF : div_quotient[15:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_tlast;
               if (drop) begin
                  zr_in = '0;
                  if (req_tlast) state_in = ST_FINISH;
               end else begin
                  zr_in      = (req_tdata != 8'd0) ? 2'd0 :
                               (zr_ff == 2'd2) ? 2'd2 : zr_ff + 2'd1;
                  sh_in      = req_tdata;
                  bit_cnt_in = 3'd7;
                  state_in   = ST_BITS;
               end
            end
         end
         ST_BITS: begin
            sh_in      = {sh_ff[6:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 3'd1;
            if (bit_cnt_ff == 3'd0) state_in = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {fields.sar_height, fields.sar_width, fr_ff,
                               fields.frame_height, fields.frame_width,
                               fields.max_ref_frames, fields.sps_index,
                               fields.level_idc, fields.profile_idc, status};
               fr_in        = '0;
               zr_in        = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         zr_ff        <= '0;
         bit_cnt_ff   <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fr_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         zr_ff        <= zr_in;
         bit_cnt_ff   <= bit_cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         fr_ff        <= fr_in;
      end
      sh_ff       <= sh_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A byte in flight keeps shifting until its eighth bit.
   `SFP_ASSERT_NEXT(a_bits_hold, clock, reset, (state_ff == ST_BITS) && (bit_cnt_ff != 3'd0), state_ff == ST_BITS)
   // A new result transaction comes only from the finish step.
   `SFP_ASSERT_IMP(a_emit_from_finish, clock, reset, $rose(rsp_tvalid), $past(state_ff) == ST_FINISH)

endmodule
`default_nettype wire

>>> sim/tb_h264_sps_field_parser_top.sv
// ----------------------------------------------------------------------------
// SPS field parser testbench
// Feeds SPS NAL units byte by byte, first from a short directed table, then
// as random but mostly well-formed units, and checks every result against a
// stated expectation or a bit-level predictor of the parser kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_h264_sps_field_parser_top;
   import sfp_pkg::*;

   // Result transaction as packed on rsp_tdata, lowest field last.
   typedef struct packed {
      logic [15:0] sar_height;
      logic [15:0] sar_width;
      logic [15:0] frame_rate;
      logic [15:0] frame_height;
      logic [15:0] frame_width;
      logic [7:0]  max_ref_frames;
      logic [4:0]  sps_index;
      logic [7:0]  level_idc;
      logic [7:0]  profile_idc;
      logic [2:0]  status;
   } sps_result_type;

   typedef struct {
      logic [7:0] data;
      bit         last;
      int         known_id;   // -1: take the expectation from the predictor
   } table_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;   // data_byte
   logic         req_tlast = 1'b0;    // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // status, profile_idc, level_idc, sps_index, max_ref_frames, frame_width,
   // frame_height, frame_rate, sar_width, sar_height
   logic [111:0] rsp_tdata;

   h264_sps_field_parser_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   // Parser state mirrored by the predictor.
   logic [5:0]  pr_phase;
   logic [1:0]  pr_zero_run;
   logic [5:0]  pr_gzeros;
   logic [31:0] pr_accum;
   logic [5:0]  pr_bits_left;
   logic [7:0]  pr_loops;
   bit          pr_is_444;
   bit          pr_frame_only;
   bit          pr_prefix;
   logic [31:0] pr_width_mbs;
   logic [31:0] pr_height_units;
   logic [32:0] pr_crop_h;
   logic [32:0] pr_crop_v;
   logic [31:0] pr_tick;
   logic [31:0] pr_scale;
   logic [2:0]  pr_err;
   sps_result_type pr_fields;

   sps_result_type expected_results[$];
   int          mismatches = 0;
   int          results_checked = 0;
   int          units_sent = 0;
   int          bytes_sent = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          status_seen[5] = '{default: 0};
   string       field_names [10] = '{"status", "profile_idc", "level_idc", "sps_index",
                                     "max_ref_frames", "frame_width", "frame_height",
                                     "frame_rate", "sar_width", "sar_height"};

   // Width of the syntax element at each phase; zero marks an Exp-Golomb code.
   function automatic logic [5:0] element_bits(input logic [5:0] ph);
      case (ph)
         PH_HDR, PH_PROF, PH_CONS, PH_LEVEL, PH_ARIDC, PH_CP, PH_TC, PH_MC: return 6'd8;
         PH_SEP, PH_BYPASS, PH_SMF, PH_SLIST, PH_DZERO, PH_GAPS, PH_FMBS, PH_MBAFF,
         PH_D8, PH_CROPF, PH_VUI, PH_ARF, PH_OVF, PH_OVA, PH_VSF, PH_VFR, PH_CDF,
         PH_CLF, PH_TIF, PH_FFR: return 6'd1;
         PH_SARW, PH_SARH: return 6'd16;
         PH_VFMT: return 6'd3;
         PH_NUT, PH_TS: return 6'd32;
         default: return 6'd0;
      endcase
   endfunction

   function automatic bit has_chroma_branch(input logic [7:0] p);
      logic [7:0] set [8] = '{8'd44, 8'd83, 8'd86, 8'd100, 8'd110, 8'd118, 8'd122, 8'd244};
      foreach (set[i]) if (p == set[i]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void enter_phase(input logic [5:0] ph);
      pr_phase = ph;
      pr_accum = '0;
      pr_gzeros = '0;
      pr_bits_left = element_bits(ph);
      pr_prefix = (element_bits(ph) == 6'd0);
   endfunction

   function automatic void stop_parse(input logic [2:0] code);
      pr_err = code;
      pr_phase = PH_HALT;
   endfunction

   function automatic void note_range();
      if (pr_err == STATUS_OK) pr_err = STATUS_RANGE;
   endfunction

   function automatic logic [15:0] cropped(input logic [63:0] full, input logic [63:0] crop);
      logic [63:0] sub;
      sub = crop * 2;
      if (sub > full || full - sub > 64'd65535) begin
         note_range();
         return 16'd0;
      end
      return 16'(full - sub);
   endfunction

   function automatic void close_size();
      logic [63:0] w, h;
      w = (64'(pr_width_mbs) + 1) * 16;
      h = (64'(pr_height_units) + 1) * 16 * (pr_frame_only ? 1 : 2);
      pr_fields.frame_width = cropped(w, 64'(pr_crop_h));
      pr_fields.frame_height = cropped(h, 64'(pr_crop_v));
      enter_phase(PH_VUI);
   endfunction

   // Acts on one complete syntax element.
   function automatic void close_element(input logic [31:0] v);
      logic [63:0] q;
      case (pr_phase)
         PH_HDR: if (v[4:0] != 5'd7) stop_parse(STATUS_NOT_SPS); else enter_phase(PH_PROF);
         PH_PROF: begin
            pr_fields.profile_idc = v[7:0];
            enter_phase(PH_CONS);
         end
         PH_CONS: enter_phase(PH_LEVEL);
         PH_LEVEL: begin
            pr_fields.level_idc = v[7:0];
            enter_phase(PH_ID);
         end
         PH_ID: begin
            if (v > 31) begin
               note_range();
               v = 31;
            end
            pr_fields.sps_index = v[4:0];
            enter_phase(has_chroma_branch(pr_fields.profile_idc) ? PH_CHROMA : PH_FRNUM);
         end
         PH_CHROMA: begin
            pr_is_444 = (v == 3);
            enter_phase(pr_is_444 ? PH_SEP : PH_LUMA);
         end
         PH_SEP: enter_phase(PH_LUMA);
         PH_LUMA: enter_phase(PH_CDEPTH);
         PH_CDEPTH: enter_phase(PH_BYPASS);
         PH_BYPASS: enter_phase(PH_SMF);
         PH_SMF: begin
            pr_loops = 0;
            enter_phase(v != 0 ? PH_SLIST : PH_FRNUM);
         end
         PH_SLIST: begin
            if (v != 0) stop_parse(STATUS_SCALING);
            else begin
               pr_loops = pr_loops + 1;
               enter_phase(pr_loops >= (pr_is_444 ? 12 : 8) ? PH_FRNUM : PH_SLIST);
            end
         end
         PH_FRNUM: enter_phase(PH_POCT);
         PH_POCT: enter_phase(v == 0 ? PH_POCLSB : v == 1 ? PH_DZERO : PH_MAXREF);
         PH_POCLSB: enter_phase(PH_MAXREF);
         PH_DZERO: enter_phase(PH_OFFNR);
         PH_OFFNR: enter_phase(PH_OFFTB);
         PH_OFFTB: enter_phase(PH_NCYC);
         PH_NCYC: begin
            if (v > 255) stop_parse(STATUS_RANGE);
            else begin
               pr_loops = v[7:0];
               enter_phase(v == 0 ? PH_MAXREF : PH_CYCOFF);
            end
         end
         PH_CYCOFF: begin
            pr_loops = pr_loops - 1;
            enter_phase(pr_loops == 0 ? PH_MAXREF : PH_CYCOFF);
         end
         PH_MAXREF: begin
            if (v > 255) begin
               note_range();
               v = 255;
            end
            pr_fields.max_ref_frames = v[7:0];
            enter_phase(PH_GAPS);
         end
         PH_GAPS: enter_phase(PH_WMBS);
         PH_WMBS: begin
            pr_width_mbs = v;
            enter_phase(PH_HMAP);
         end
         PH_HMAP: begin
            pr_height_units = v;
            enter_phase(PH_FMBS);
         end
         PH_FMBS: begin
            pr_frame_only = v[0];
            enter_phase(v != 0 ? PH_D8 : PH_MBAFF);
         end
         PH_MBAFF: enter_phase(PH_D8);
         PH_D8: enter_phase(PH_CROPF);
         PH_CROPF: if (v != 0) enter_phase(PH_CL); else close_size();
         PH_CL: begin
            pr_crop_h = 33'(v);
            enter_phase(PH_CR);
         end
         PH_CR: begin
            pr_crop_h = pr_crop_h + 33'(v);
            enter_phase(PH_CT);
         end
         PH_CT: begin
            pr_crop_v = 33'(v);
            enter_phase(PH_CB);
         end
         PH_CB: begin
            pr_crop_v = pr_crop_v + 33'(v);
            close_size();
         end
         PH_VUI: enter_phase(v != 0 ? PH_ARF : PH_DONE);
         PH_ARF: enter_phase(v != 0 ? PH_ARIDC : PH_OVF);
         PH_ARIDC: enter_phase(v == 255 ? PH_SARW : PH_OVF);
         PH_SARW: begin
            pr_fields.sar_width = v[15:0];
            enter_phase(PH_SARH);
         end
         PH_SARH: begin
            pr_fields.sar_height = v[15:0];
            enter_phase(PH_OVF);
         end
         PH_OVF: enter_phase(v != 0 ? PH_OVA : PH_VSF);
         PH_OVA: enter_phase(PH_VSF);
         PH_VSF: enter_phase(v != 0 ? PH_VFMT : PH_CLF);
         PH_VFMT: enter_phase(PH_VFR);
         PH_VFR: enter_phase(PH_CDF);
         PH_CDF: enter_phase(v != 0 ? PH_CP : PH_CLF);
         PH_CP: enter_phase(PH_TC);
         PH_TC: enter_phase(PH_MC);
         PH_MC: enter_phase(PH_CLF);
         PH_CLF: enter_phase(v != 0 ? PH_CLT : PH_TIF);
         PH_CLT: enter_phase(PH_CLB);
         PH_CLB: enter_phase(PH_TIF);
         PH_TIF: enter_phase(v != 0 ? PH_NUT : PH_DONE);
         PH_NUT: begin
            pr_tick = v;
            enter_phase(PH_TS);
         end
         PH_TS: begin
            pr_scale = v;
            enter_phase(PH_FFR);
         end
         PH_FFR: begin
            if (v != 0 && pr_tick != 0) begin
               q = 64'(pr_scale) / (64'(pr_tick) * 2);
               pr_fields.frame_rate = q > 64'd65535 ? 16'hFFFF : q[15:0];
            end
            enter_phase(PH_DONE);
         end
         default: pr_phase = PH_HALT;
      endcase
   endfunction

   // Consumes one payload bit, MSB first.
   function automatic void take_bit(input bit b);
      logic [31:0] v;
      if (pr_phase >= PH_DONE) return;
      if (pr_prefix) begin
         if (!b) begin
            pr_gzeros = pr_gzeros + 1;
            if (pr_gzeros >= 32) stop_parse(STATUS_RANGE);
         end else if (pr_gzeros == 0) begin
            close_element(32'd0);
         end else begin
            pr_prefix = 1'b0;
            pr_bits_left = pr_gzeros;
            pr_accum = '0;
         end
         return;
      end
      pr_accum = {pr_accum[30:0], b};
      if (pr_bits_left > 0) pr_bits_left = pr_bits_left - 1;
      if (pr_bits_left == 0) begin
         v = pr_accum;
         if (element_bits(pr_phase) == 0) v = v + ((32'd1 << pr_gzeros[4:0]) - 1);
         close_element(v);
      end
   endfunction

   function automatic void clear_parser();
      pr_zero_run = 0;
      pr_loops = 0;
      pr_is_444 = 0;
      pr_frame_only = 1;
      pr_width_mbs = 0;
      pr_height_units = 0;
      pr_crop_h = 0;
      pr_crop_v = 0;
      pr_tick = 0;
      pr_scale = 0;
      pr_fields = '0;
      pr_err = STATUS_OK;
      enter_phase(PH_HDR);
   endfunction

   // Advances the predictor by one accepted byte; returns 1 with a result at the last byte.
   function automatic bit parse_byte(input logic [7:0] b, input bit last,
                                     output sps_result_type res);
      res = '0;
      if (pr_zero_run >= 2 && b == 8'h03) begin
         pr_zero_run = 0;
      end else begin
         pr_zero_run = (b == 0) ? (pr_zero_run >= 2 ? 2'd2 : pr_zero_run + 2'd1) : 2'd0;
         for (int i = 7; i >= 0; i--) take_bit(b[i]);
      end
      if (!last) return 1'b0;
      res = pr_fields;
      res.status = (pr_phase != PH_HALT && pr_phase != PH_DONE) ? STATUS_TRUNCATED : pr_err;
      clear_parser();
      return 1'b1;
   endfunction

   function automatic sps_result_type fixed_result(input logic [2:0] st,
                                                   input logic [7:0] prof,
                                                   input logic [7:0] lvl,
                                                   input logic [15:0] w,
                                                   input logic [15:0] h);
      sps_result_type r;
      r = '0;
      r.status = st;
      r.profile_idc = prof;
      r.level_idc = lvl;
      r.frame_width = w;
      r.frame_height = h;
      return r;
   endfunction

   // Results of the directed units that can be stated outright.
   function automatic sps_result_type known_result(input int id);
      case (id)
         0: return fixed_result(STATUS_NOT_SPS, 8'h00, 8'h00, 16'd0, 16'd0);
         1: return fixed_result(STATUS_TRUNCATED, 8'h00, 8'h00, 16'd0, 16'd0);
         2: return fixed_result(STATUS_OK, 8'h42, 8'h1E, 16'd16, 16'd16);
         3: return fixed_result(STATUS_RANGE, 8'h42, 8'h00, 16'd0, 16'd0);
         default: return fixed_result(STATUS_TRUNCATED, 8'h42, 8'h00, 16'd0, 16'd0);
      endcase
   endfunction

   // Drives one byte, honoring the burst and gap pattern; returns after acceptance.
   task automatic send_byte(input logic [7:0] b, input bit last, input int known_id);
      sps_result_type res;
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (parse_byte(b, last, res)) begin
         units_sent++;
         expected_results.push_back(known_id >= 0 ? known_result(known_id) : res);
      end
      @(negedge clock);
   endtask

   // Random unit construction: payload bits, then bytes with emulation prevention.
   bit          unit_bits[$];
   logic [7:0]  unit_bytes[$];

   task automatic put_bits(input logic [31:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) unit_bits.push_back(v[i]);
   endtask

   task automatic put_ue(input logic [31:0] v);
      logic [32:0] x;
      int nb;
      x = 33'(v) + 1;
      nb = 0;
      while ((x >> nb) > 1) nb++;
      repeat (nb) unit_bits.push_back(1'b0);
      for (int i = nb; i >= 0; i--) unit_bits.push_back(x[i]);
   endtask

   function automatic logic [31:0] pick_ue(input int rare_pct, input int common_max,
                                           input int rare_max);
      return $urandom_range(0, 99) < rare_pct ? $urandom_range(0, rare_max)
                                              : $urandom_range(0, common_max);
   endfunction

   task automatic build_sps_unit();
      logic [7:0] prof, aspect;
      logic [31:0] poc_type, cycles, chroma;
      bit is444;
      int zc, cut;
      logic [7:0] b;
      logic [7:0] high_list [8] = '{8'd44, 8'd83, 8'd86, 8'd100, 8'd110, 8'd118, 8'd122, 8'd244};
      unit_bits.delete();
      unit_bytes.delete();
      put_bits($urandom_range(0, 19) == 0 ? $urandom_range(0, 255)
                                          : {24'd0, 3'($urandom_range(0, 7)), 5'd7}, 8);
      prof = $urandom_range(0, 1) ? high_list[$urandom_range(0, 7)] : 8'($urandom);
      put_bits(prof, 8);
      put_bits($urandom_range(0, 255), 8);
      put_bits($urandom_range(0, 255), 8);
      if ($urandom_range(0, 39) == 0) put_bits(32'd0, 32);   // Golomb code too long
      put_ue(pick_ue(8, 31, 60));
      if (has_chroma_branch(prof)) begin
         chroma = pick_ue(10, 3, 7);
         put_ue(chroma);
         is444 = (chroma == 32'd3);
         if (is444) put_bits($urandom_range(0, 1), 1);
         put_ue(pick_ue(5, 6, 40));
         put_ue(pick_ue(5, 6, 40));
         put_bits($urandom_range(0, 1), 1);
         if ($urandom_range(0, 3) == 0) begin
            put_bits(1, 1);
            repeat (is444 ? 12 : 8) put_bits($urandom_range(0, 15) == 0, 1);
         end else begin
            put_bits(0, 1);
         end
      end
      put_ue(pick_ue(5, 12, 100000));
      poc_type = pick_ue(5, 2, 6);
      put_ue(poc_type);
      if (poc_type == 0) put_ue(pick_ue(5, 12, 1000));
      else if (poc_type == 1) begin
         put_bits($urandom_range(0, 1), 1);
         put_ue(pick_ue(10, 20, 70000));
         put_ue(pick_ue(10, 20, 70000));
         cycles = pick_ue(5, 4, 300);
         put_ue(cycles);
         for (int i = 0; i < cycles && i < 256; i++) put_ue(pick_ue(5, 30, 5000));
      end
      put_ue(pick_ue(5, 16, 400));
      put_bits($urandom_range(0, 1), 1);
      put_ue(pick_ue(5, 120, 5000));
      put_ue(pick_ue(5, 70, 5000));
      b = 8'($urandom_range(0, 1));
      put_bits(b, 1);
      if (b == 8'd0) put_bits($urandom_range(0, 1), 1);
      put_bits($urandom_range(0, 1), 1);
      if ($urandom_range(0, 1)) begin
         put_bits(1, 1);
         repeat (4) put_ue(pick_ue(5, 10, 40000));
      end else begin
         put_bits(0, 1);
      end
      if ($urandom_range(0, 4) != 0) begin
         put_bits(1, 1);
         if ($urandom_range(0, 1)) begin
            put_bits(1, 1);
            aspect = $urandom_range(0, 1) ? 8'd255 : 8'($urandom);
            put_bits(aspect, 8);
            if (aspect == 8'd255) begin
               put_bits($urandom, 16);
               put_bits($urandom, 16);
            end
         end else put_bits(0, 1);
         b = 8'($urandom_range(0, 1));
         put_bits(b, 1);
         if (b != 8'd0) put_bits($urandom_range(0, 1), 1);
         b = 8'($urandom_range(0, 1));
         put_bits(b, 1);
         if (b != 8'd0) begin
            put_bits($urandom_range(0, 7), 3);
            put_bits($urandom_range(0, 1), 1);
            b = 8'($urandom_range(0, 1));
            put_bits(b, 1);
            if (b != 8'd0) put_bits($urandom, 24);
         end
         b = 8'($urandom_range(0, 1));
         put_bits(b, 1);
         if (b != 8'd0) begin
            put_ue(pick_ue(5, 5, 100));
            put_ue(pick_ue(5, 5, 100));
         end
         b = 8'($urandom_range(0, 4) != 0);
         put_bits(b, 1);
         if (b != 8'd0) begin
            put_bits($urandom_range(0, 9) == 0 ? 32'd0 :
                     $urandom_range(0, 1) ? $urandom_range(1, 5000) : $urandom, 32);
            put_bits($urandom_range(0, 1) ? $urandom_range(0, 200000) : $urandom, 32);
            put_bits($urandom_range(0, 3) != 0, 1);
         end
      end else begin
         put_bits(0, 1);
      end
      // Stop bit and byte alignment, then random trailing bits.
      put_bits(1, 1);
      while (unit_bits.size() % 8 != 0) unit_bits.push_back(1'b0);
      repeat ($urandom_range(0, 2) * 8) unit_bits.push_back(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, unit_bits.size() / 8);
         unit_bits = unit_bits[0:cut * 8 - 1];
      end
      zc = 0;
      for (int i = 0; i < unit_bits.size(); i += 8) begin
         for (int k = 0; k < 8; k++) b[7 - k] = unit_bits[i + k];
         if (zc >= 2 && b <= 8'h03) begin
            unit_bytes.push_back(8'h03);
            zc = 0;
         end
         unit_bytes.push_back(b);
         zc = (b == 0) ? zc + 1 : 0;
      end
      // Sometimes the unit ends on an emulation-prevention byte.
      if ($urandom_range(0, 19) == 0) begin
         unit_bytes.push_back(8'h00);
         unit_bytes.push_back(8'h00);
         unit_bytes.push_back(8'h03);
      end
   endtask

   // Receiver: rx_mode picks the ready pattern at random, including always-ready stretches.
   int rx_cycle = 0;
   int rx_mode = 0;
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (rx_cycle % 5 == 0);
      endcase
   end

   // Result checking and idle watchdog.
   always @(posedge clock) begin
      sps_result_type got, want;
      logic [15:0] g [10], w [10];
      bit bad;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 4000) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("tb_h264_sps_field_parser_top: done, errors");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = sps_result_type'(rsp_tdata);
            if (expected_results.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result transaction %h", rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               g = '{16'(got.status), 16'(got.profile_idc), 16'(got.level_idc),
                     16'(got.sps_index), 16'(got.max_ref_frames), got.frame_width,
                     got.frame_height, got.frame_rate, got.sar_width, got.sar_height};
               w = '{16'(want.status), 16'(want.profile_idc), 16'(want.level_idc),
                     16'(want.sps_index), 16'(want.max_ref_frames), want.frame_width,
                     want.frame_height, want.frame_rate, want.sar_width, want.sar_height};
               bad = 1'b0;
               for (int i = 0; i < 10; i++) begin
                  if (g[i] !== w[i]) begin
                     if (mismatches < 10)
                        $display("result %0d: %s expected %0d, got %0d",
                                 results_checked, field_names[i], w[i], g[i]);
                     bad = 1'b1;
                  end
               end
               if (bad) mismatches <= mismatches + 1;
               if (want.status <= STATUS_RANGE) status_seen[want.status]++;
               results_checked <= results_checked + 1;
            end
         end
      end
   end

   table_row_type directed [] = '{
      '{8'h08, 1, 0},
      '{8'h67, 1, 1},
      '{8'h67, 0, 2}, '{8'h42, 0, 2}, '{8'h00, 0, 2}, '{8'h1E, 0, 2}, '{8'hFB, 0, 2},
      '{8'h80, 1, 2},
      '{8'h67, 0, 3}, '{8'h42, 0, 3}, '{8'h00, 0, 3}, '{8'h00, 0, 3}, '{8'h00, 0, 3},
      '{8'h00, 0, 3}, '{8'h00, 0, 3}, '{8'h00, 0, 3}, '{8'h00, 1, 3},
      '{8'h67, 0, 4}, '{8'h42, 0, 4}, '{8'h00, 0, 4}, '{8'h00, 0, 4}, '{8'h03, 1, 4},
      '{8'h67, 0, -1}, '{8'h64, 0, -1}, '{8'hFF, 0, -1}, '{8'hFF, 0, -1}, '{8'hFF, 1, -1}
   };

   // Stimulus: reset, directed table, then random units.
   initial begin
      int random_bytes;
      clear_parser();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send_byte(directed[i].data, directed[i].last, directed[i].known_id);
      random_bytes = 0;
      while (random_bytes < 1600) begin
         if ($urandom_range(0, 11) == 0) begin
            unit_bytes.delete();
            repeat ($urandom_range(1, 8)) unit_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_sps_unit();
         end
         foreach (unit_bytes[i]) send_byte(unit_bytes[i], i == unit_bytes.size() - 1, -1);
         random_bytes += unit_bytes.size();
      end
      req_tvalid = 1'b0;
      req_tlast = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d bytes in %0d NAL units, checked %0d results", bytes_sent,
               units_sent, results_checked);
      $display("status mix ok/not-sps/truncated/scaling/range: %0d/%0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb_h264_sps_field_parser_top: done, clean");
      end else begin
         $display("mismatches: %0d", mismatches);
         $display("tb_h264_sps_field_parser_top: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sfp_pkg.sv
rtl/core/sfp_divider.sv
rtl/core/sfp_field_parser.sv
rtl/core/h264_sps_field_parser_top.sv
sim/tb_h264_sps_field_parser_top.sv
